### design/ilid_pkg.sv
// shared constants and types for the indexed list insert/delete unit
`default_nettype none
package ilid_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int EIDX_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CMD_W      = 3;
    localparam int POS_W      = 7;
    localparam int VAL_W      = 32;
    localparam int STAT_W     = 2;
    localparam int IDX_W      = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_EDIT   = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_READ   = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        S_RUN,
        S_READ
    } state_t;

    // what one cell loads in a cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_NEW,
        OP_LOWER,
        OP_UPPER,
        OP_HEAD,
        OP_ZERO
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic signed [VAL_W-1:0] new_value;
    } cell_ctl_t;

endpackage
`default_nettype wire

### design/ilid_in_if.sv
// request channel: command, position and value
`default_nettype none
interface ilid_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [ilid_pkg::CMD_W-1:0]           cmd;
    logic [ilid_pkg::POS_W-1:0]           position;
    logic signed [ilid_pkg::VAL_W-1:0]    item_value;

    modport source (output valid, cmd, position, item_value, input ready);
    modport sink   (input valid, cmd, position, item_value, output ready);
endinterface
`default_nettype wire

### design/ilid_out_if.sv
// response channel: status, value, index and last flag
`default_nettype none
interface ilid_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [ilid_pkg::STAT_W-1:0]          status;
    logic signed [ilid_pkg::VAL_W-1:0]    result_value;
    logic [ilid_pkg::IDX_W-1:0]           result_index;
    logic                                 last;

    modport source (output valid, status, result_value, result_index, last, input ready);
    modport sink   (input valid, status, result_value, result_index, last, output ready);
endinterface
`default_nettype wire

### design/indexed_list_insert_delete_unit.sv
// top level: command decode, output register and the row of entry cells
//
// Keeps a packed list of up to LIST_DEPTH signed 32-bit entries in a row of
// cells plus a fill count. Requests arrive on req (cmd, position,
// item_value); responses leave on rsp (status, result_value, result_index,
// last). Both are valid/ready channels; a word moves when both are high.
// Append, insert, edit, delete and clear are taken one per cycle while the
// output register is free: all cells shift or load in the same edge, and the
// single response word is loaded into the output register on that edge.
// Read all takes the request and then sends count words, one per cycle while
// rsp is ready: each cycle the word of cell 0 goes out and the filled part of
// the row rotates down by one, so after count steps the list is back in its
// original order. No request is taken during the read-out.
// Errors (full, bad index, empty) give one word with zeros and last set and
// change no state. Commands 6 and 7 are taken and answered with nothing.
// Reset clears all entries and the count and empties the output register.
// When rsp stalls, the word waits in the output register; a new request is
// taken only in a cycle where that register is empty or being emptied.
`default_nettype none
module indexed_list_insert_delete_unit (
    input  wire        clk,
    input  wire        rst_n,
    ilid_in_if.sink    req,
    ilid_out_if.source rsp
);

    localparam int N      = ilid_pkg::LIST_DEPTH;
    localparam int CNT_W  = ilid_pkg::CNT_W;
    localparam int EIDX_W = ilid_pkg::EIDX_W;
    localparam int POS_W  = ilid_pkg::POS_W;
    localparam int VAL_W  = ilid_pkg::VAL_W;
    localparam int STAT_W = ilid_pkg::STAT_W;
    localparam int IDX_W  = ilid_pkg::IDX_W;

    ilid_pkg::state_t        state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [EIDX_W-1:0]       rd_idx_reg, rd_idx_next;

    logic                    out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]       out_status_reg, out_status_next;
    logic signed [VAL_W-1:0] out_value_reg, out_value_next;
    logic [IDX_W-1:0]        out_index_reg, out_index_next;
    logic                    out_last_reg, out_last_next;

    logic signed [VAL_W-1:0] cell_q [N];

    logic                    slot_free;
    logic                    accept;
    logic [POS_W-1:0]        count_p;
    logic                    is_full;
    logic                    is_empty;
    logic                    rd_last;
    logic                    do_app, do_ins, do_edit, do_del, do_clr, do_rot;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ilid_pkg::S_RUN) && slot_free;
    assign accept    = req.valid && req.ready;
    assign count_p   = POS_W'(count_reg);
    assign is_full   = (count_reg == CNT_W'(N));
    assign is_empty  = (count_reg == '0);
    assign rd_last   = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);

    // state updates that actually touch the cells
    assign do_app  = accept && (req.cmd == ilid_pkg::CMD_APPEND) && !is_full;
    assign do_ins  = accept && (req.cmd == ilid_pkg::CMD_INSERT) && !is_full
                     && (req.position <= count_p);
    assign do_edit = accept && (req.cmd == ilid_pkg::CMD_EDIT) && !is_empty
                     && (req.position < count_p);
    assign do_del  = accept && (req.cmd == ilid_pkg::CMD_DELETE) && !is_empty
                     && (req.position < count_p);
    assign do_clr  = accept && (req.cmd == ilid_pkg::CMD_CLEAR);
    assign do_rot  = (state_reg == ilid_pkg::S_READ) && slot_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ilid_pkg::S_RUN:
                if (accept && (req.cmd == ilid_pkg::CMD_READ) && !is_empty)
                    state_next = ilid_pkg::S_READ;
            ilid_pkg::S_READ:
                if (do_rot && rd_last)
                    state_next = ilid_pkg::S_RUN;
            default:
                state_next = ilid_pkg::S_RUN;
        endcase
    end

    // count, read pointer and output word
    always_comb
    begin
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        out_last_next   = out_last_reg;

        if (accept)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ilid_pkg::ST_OK;
            out_value_next  = req.item_value;
            out_index_next  = IDX_W'(req.position);
            out_last_next   = 1'b1;
            case (req.cmd) inside
                ilid_pkg::CMD_APPEND:
                begin
                    out_index_next = IDX_W'(count_reg);
                    if (is_full)
                        out_status_next = ilid_pkg::ST_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                ilid_pkg::CMD_INSERT:
                begin
                    if (is_full)
                        out_status_next = ilid_pkg::ST_FULL;
                    else if (req.position > count_p)
                        out_status_next = ilid_pkg::ST_RANGE;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                ilid_pkg::CMD_EDIT, ilid_pkg::CMD_DELETE:
                begin
                    if (req.cmd == ilid_pkg::CMD_DELETE)
                        out_value_next = cell_q[req.position[EIDX_W-1:0]];
                    if (is_empty)
                        out_status_next = ilid_pkg::ST_EMPTY;
                    else if (req.position >= count_p)
                        out_status_next = ilid_pkg::ST_RANGE;
                    else if (req.cmd == ilid_pkg::CMD_DELETE)
                        count_next = count_reg - CNT_W'(1);
                end
                ilid_pkg::CMD_READ:
                begin
                    rd_idx_next = '0;
                    if (is_empty)
                        out_status_next = ilid_pkg::ST_EMPTY;
                    else
                        out_valid_next = out_valid_reg && !rsp.ready;
                end
                ilid_pkg::CMD_CLEAR:
                begin
                    count_next     = '0;
                    out_value_next = '0;
                    out_index_next = '0;
                end
                default:
                    out_valid_next = out_valid_reg && !rsp.ready;
            endcase
            // error words carry zeros
            if (out_status_next != ilid_pkg::ST_OK)
            begin
                out_value_next = '0;
                out_index_next = '0;
            end
        end
        else if (do_rot)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ilid_pkg::ST_OK;
            out_value_next  = cell_q[0];
            out_index_next  = IDX_W'(rd_idx_reg);
            out_last_next   = rd_last;
            rd_idx_next     = rd_idx_reg + EIDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ilid_pkg::S_RUN;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.result_index = out_index_reg;
    assign rsp.last         = out_last_reg;

    // row of cells
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        localparam logic [POS_W-1:0] CELL_IDX = POS_W'(i);
        localparam logic [POS_W-1:0] CELL_NXT = POS_W'(i + 1);

        ilid_pkg::cell_ctl_t     ctl;
        logic signed [VAL_W-1:0] lower;
        logic signed [VAL_W-1:0] upper;

        if (i == 0)
        begin : g_lo_edge
            assign lower = '0;
        end
        else
        begin : g_lo
            assign lower = cell_q[i-1];
        end

        if (i == N - 1)
        begin : g_hi_edge
            assign upper = '0;
        end
        else
        begin : g_hi
            assign upper = cell_q[i+1];
        end

        always_comb
        begin
            ctl.new_value = req.item_value;
            ctl.op        = ilid_pkg::OP_HOLD;
            if (do_clr)
                ctl.op = ilid_pkg::OP_ZERO;
            else if (do_app && (CELL_IDX == count_p))
                ctl.op = ilid_pkg::OP_NEW;
            else if ((do_ins || do_edit) && (CELL_IDX == req.position))
                ctl.op = ilid_pkg::OP_NEW;
            else if (do_ins && (CELL_IDX > req.position) && (CELL_IDX <= count_p))
                ctl.op = ilid_pkg::OP_LOWER;
            else if (do_del && (CELL_NXT == count_p))
                ctl.op = ilid_pkg::OP_ZERO;
            else if (do_del && (CELL_IDX >= req.position) && (CELL_NXT < count_p))
                ctl.op = ilid_pkg::OP_UPPER;
            else if (do_rot && (CELL_NXT == count_p))
                ctl.op = ilid_pkg::OP_HEAD;
            else if (do_rot && (CELL_NXT < count_p))
                ctl.op = ilid_pkg::OP_UPPER;
        end

        ilid_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .lower (lower),
            .upper (upper),
            .head  (cell_q[0]),
            .value (cell_q[i])
        );
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(N))
        else $error("list count above depth");

    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ilid_pkg::ST_OK)) |->
            (rsp.last && (rsp.result_value == '0) && (rsp.result_index == '0)))
        else $error("error word not zeroed or not last");

    a_full_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == ilid_pkg::CMD_APPEND) && is_full) |=>
            (rsp.valid && (rsp.status == ilid_pkg::ST_FULL) && $stable(count_reg)))
        else $error("append to full list not answered with full");

    a_read_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ilid_pkg::S_READ) |=> (count_reg == $past(count_reg)))
        else $error("count changed during read-out");

    a_read_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ilid_pkg::S_READ) |-> !req.ready)
        else $error("request taken during read-out");

endmodule
`default_nettype wire

### design/ilid_cell.sv
// one list entry cell, loading from its neighbors, the head or a new value
`default_nettype none
module ilid_cell (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire ilid_pkg::cell_ctl_t         ctl,
    input  wire logic signed [ilid_pkg::VAL_W-1:0] lower,
    input  wire logic signed [ilid_pkg::VAL_W-1:0] upper,
    input  wire logic signed [ilid_pkg::VAL_W-1:0] head,
    output logic signed [ilid_pkg::VAL_W-1:0]      value
);

    logic signed [ilid_pkg::VAL_W-1:0] value_reg;
    logic signed [ilid_pkg::VAL_W-1:0] value_next;

    always_comb
    begin
        unique case (ctl.op)
            ilid_pkg::OP_HOLD:  value_next = value_reg;
            ilid_pkg::OP_NEW:   value_next = ctl.new_value;
            ilid_pkg::OP_LOWER: value_next = lower;
            ilid_pkg::OP_UPPER: value_next = upper;
            ilid_pkg::OP_HEAD:  value_next = head;
            ilid_pkg::OP_ZERO:  value_next = '0;
            default:            value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= '0;
        else
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
`default_nettype wire
